### sv/wspd_pkg.sv
// shared constants and types for the working set phase detector
package wspd_pkg;
	localparam int SigLog2 = 10;
	localparam int MaxPhases = 16;
	localparam int SigBits = 1 << SigLog2;
	localparam int SigWords = SigBits / 64;
	localparam int WordW = (SigWords > 1) ? $clog2(SigWords) : 1;
	localparam int PhW = (MaxPhases > 1) ? $clog2(MaxPhases) : 1;
	localparam int CntW = $clog2(MaxPhases + 1);
	localparam int PopW = SigLog2 + 1;
	localparam int WPopW = 7;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam logic [63:0] HashMult = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] HashLo = HashMult[31:0];
	localparam logic [31:0] HashHi = HashMult[63:32];
	localparam logic [1:0] RegInterval = 2'd0;
	localparam logic [1:0] RegThresh = 2'd1;
	localparam logic [1:0] RegStable = 2'd2;
	localparam logic [1:0] RegDrop = 2'd3;
	localparam logic [4:0] PhaseNone = 5'h1f;

	// a closed interval handed from front to back
	typedef struct packed {
		logic [SigBits-1:0] sig;
	} wspd_job_t;
endpackage

### sv/wspd_front.sv
// front: hashes addresses into the signature and closes intervals
module wspd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [63:0]             instr_address,
	input  logic [31:0]             interval_length,
	input  logic                    interval_wr,
	input  logic [5:0]              dropped_low_bits,
	input  logic                    q_full,
	output logic                    q_push,
	output wspd_pkg::wspd_job_t     q_job
);
	logic [wspd_pkg::SigBits-1:0] cur_sig_q;
	logic [31:0]  count_q;
	logic [31:0]  mod_q;
	logic         busy_q;
	logic [31:0]  rem_q;
	logic [31:0]  num_q;
	logic [5:0]   step_q;
	logic [32:0]  rem_sh;
	logic [32:0]  rem_diff;
	logic [31:0]  rem_next;
	logic         v_s1;
	logic [63:0]  shifted_s1;
	logic         bnd_s1;
	logic         v_s2;
	logic [31:0]  lo_s2;
	logic [31:0]  cross_a_s2;
	logic [31:0]  cross_b_s2;
	logic         bnd_s2;
	logic [63:0]  mul_lo;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [31:0]  hash;
	logic [wspd_pkg::SigLog2-1:0] idx;
	logic [wspd_pkg::SigBits-1:0] merged;
	logic         bnd_now;
	logic         stall;
	logic         take;

	// hold the pipeline while a boundary waits for queue space
	assign stall = v_s2 && bnd_s2 && q_full;
	assign full = stall || busy_q || interval_wr;
	assign take = push && !full;

	// boundary when the running remainder is zero
	assign bnd_now = (mod_q == 32'd0);

	// one restoring remainder step of count over the interval length
	always_comb begin
		rem_sh = {rem_q, num_q[31]};
		if (rem_sh >= {1'b0, interval_length})
			rem_diff = rem_sh - {1'b0, interval_length};
		else
			rem_diff = rem_sh;
		rem_next = rem_diff[31:0];
	end

	// instruction counter and its remainder, rebuilt after an interval write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mod_q <= '0;
			busy_q <= 1'b0;
			rem_q <= '0;
			num_q <= '0;
			step_q <= '0;
		end else if (interval_wr) begin
			busy_q <= 1'b1;
			rem_q <= '0;
			num_q <= count_q;
			step_q <= 6'd32;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[30:0], 1'b0};
			step_q <= step_q - 6'd1;
			if (step_q == 6'd1) begin
				busy_q <= 1'b0;
				mod_q <= rem_next;
			end
		end else if (take) begin
			count_q <= count_q + 32'd1;
			if (interval_length == 32'd0)
				mod_q <= count_q + 32'd1;
			else if (count_q == 32'hFFFF_FFFF || mod_q + 32'd1 >= interval_length)
				mod_q <= '0;
			else
				mod_q <= mod_q + 32'd1;
		end
	end

	// stage 1: shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= take;
			if (take) begin
				shifted_s1 <= instr_address >> dropped_low_bits;
				bnd_s1 <= bnd_now;
			end
		end
	end

	// partial products of the hash, only bits 63..32 of the product are kept
	assign mul_lo = {32'd0, shifted_s1[31:0]} * {32'd0, wspd_pkg::HashLo};
	assign mul_a = shifted_s1[63:32] * wspd_pkg::HashLo;
	assign mul_b = shifted_s1[31:0] * wspd_pkg::HashHi;

	// stage 2: hash multiply in 32 bit pieces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				lo_s2 <= mul_lo[63:32];
				cross_a_s2 <= mul_a;
				cross_b_s2 <= mul_b;
				bnd_s2 <= bnd_s1;
			end
		end
	end

	assign hash = lo_s2 + cross_a_s2 + cross_b_s2;
	assign idx = hash[31 -: wspd_pkg::SigLog2];
	always_comb begin
		merged = cur_sig_q;
		merged[idx] = 1'b1;
	end
	assign q_push = v_s2 && bnd_s2 && !q_full;
	assign q_job.sig = merged;

	// stage 3: signature accumulate, cleared at a boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sig_q <= '0;
		end else if (v_s2 && !stall) begin
			cur_sig_q <= bnd_s2 ? '0 : merged;
		end
	end
endmodule

### sv/wspd_back.sv
// back: compares signatures, records and searches the phase table
module wspd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_take,
	input  wspd_pkg::wspd_job_t     job,
	input  logic [8:0]              threshold_q8,
	input  logic [7:0]              stable_intervals_needed,
	output logic                    res_valid,
	input  logic                    res_take,
	output logic [4:0]              phase_id,
	output logic                    phase_created
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_CMP, ST_DEC, ST_RD, ST_SCMP, ST_SDEC, ST_OUT
	} state_t;
	state_t state_q;
	logic [wspd_pkg::SigBits-1:0] prev_q;
	logic [wspd_pkg::SigBits-1:0] cur_q;
	logic [wspd_pkg::SigBits-1:0] mem [wspd_pkg::MaxPhases];
	logic [wspd_pkg::SigBits-1:0] rd_q;
	logic [wspd_pkg::CntW-1:0] entries_q;
	logic [wspd_pkg::CntW-1:0] p_q;
	logic [wspd_pkg::WordW-1:0] w_q;
	logic [7:0]  stable_q;
	logic [4:0]  phase_q;
	logic        created_q;
	logic        res_q;
	logic [4:0]  res_id_q;
	logic        res_created_q;
	logic [wspd_pkg::PopW-1:0] nx_q;
	logic [wspd_pkg::PopW-1:0] no_q;
	logic [wspd_pkg::PopW-1:0] bx_q;
	logic [wspd_pkg::PopW-1:0] bo_q;
	logic [63:0] cur_w;
	logic [63:0] oth_w;
	logic [wspd_pkg::WPopW-1:0] pc_x;
	logic [wspd_pkg::WPopW-1:0] pc_o;
	logic        last_w;
	logic [7:0]  stable_inc;
	logic [wspd_pkg::PopW+8:0] lhs;
	logic [wspd_pkg::PopW+8:0] rhs;
	logic [2*wspd_pkg::PopW-1:0] c1;
	logic [2*wspd_pkg::PopW-1:0] c2;
	logic        below;
	logic        wr_en;

	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign res_valid = res_q;
	assign phase_id = res_id_q;
	assign phase_created = res_created_q;

	// one 64 bit word of each signature per cycle
	assign cur_w = cur_q[{w_q, 6'd0} +: 64];
	assign oth_w = (state_q == ST_CMP) ? prev_q[{w_q, 6'd0} +: 64] : rd_q[{w_q, 6'd0} +: 64];
	assign last_w = (w_q == wspd_pkg::WordW'(wspd_pkg::SigWords - 1));

	// population counts of xor and or within a word
	always_comb begin
		pc_x = '0;
		pc_o = '0;
		for (int i = 0; i < 64; i++) begin
			pc_x = pc_x + wspd_pkg::WPopW'(cur_w[i] ^ oth_w[i]);
			pc_o = pc_o + wspd_pkg::WPopW'(cur_w[i] | oth_w[i]);
		end
	end

	// threshold and best-so-far cross products
	assign lhs = {1'b0, nx_q, 8'd0};
	assign rhs = {{wspd_pkg::PopW{1'b0}}, threshold_q8} * {9'd0, no_q};
	assign below = (no_q != '0) && (lhs < rhs);
	assign c1 = {{wspd_pkg::PopW{1'b0}}, nx_q} * {{wspd_pkg::PopW{1'b0}}, bo_q};
	assign c2 = {{wspd_pkg::PopW{1'b0}}, bx_q} * {{wspd_pkg::PopW{1'b0}}, no_q};
	assign stable_inc = (stable_q != 8'hff) ? stable_q + 8'd1 : stable_q;
	assign wr_en = (state_q == ST_DEC) && below && (stable_inc >= stable_intervals_needed) &&
		(phase_q == wspd_pkg::PhaseNone) &&
		(entries_q < wspd_pkg::CntW'(wspd_pkg::MaxPhases));

	// phase table memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[entries_q[wspd_pkg::PhW-1:0]] <= cur_q;
		rd_q <= mem[p_q[wspd_pkg::PhW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q <= '0;
			entries_q <= '0;
			stable_q <= '0;
			phase_q <= wspd_pkg::PhaseNone;
			res_q <= 1'b0;
			res_id_q <= wspd_pkg::PhaseNone;
			res_created_q <= 1'b0;
			created_q <= 1'b0;
			p_q <= '0;
			w_q <= '0;
		end else begin
			// result register, loaded when a decision is ready
			if (state_q == ST_OUT && (!res_q || res_take)) begin
				res_q <= 1'b1;
				res_id_q <= phase_q;
				res_created_q <= created_q;
			end else if (res_take) begin
				res_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						cur_q <= job.sig;
						nx_q <= '0;
						no_q <= '0;
						w_q <= '0;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					nx_q <= nx_q + wspd_pkg::PopW'(pc_x);
					no_q <= no_q + wspd_pkg::PopW'(pc_o);
					w_q <= w_q + 1'b1;
					if (last_w)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					created_q <= wr_en;
					prev_q <= cur_q;
					if (below) begin
						stable_q <= stable_inc;
						if (wr_en) begin
							phase_q <= 5'(entries_q);
							entries_q <= entries_q + 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						stable_q <= '0;
						phase_q <= wspd_pkg::PhaseNone;
						bx_q <= wspd_pkg::PopW'(threshold_q8);
						bo_q <= wspd_pkg::PopW'(256);
						p_q <= '0;
						state_q <= (entries_q == '0) ? ST_OUT : ST_RD;
					end
				end
				ST_RD: begin
					nx_q <= '0;
					no_q <= '0;
					w_q <= '0;
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					nx_q <= nx_q + wspd_pkg::PopW'(pc_x);
					no_q <= no_q + wspd_pkg::PopW'(pc_o);
					w_q <= w_q + 1'b1;
					if (last_w)
						state_q <= ST_SDEC;
				end
				ST_SDEC: begin
					if (below && c1 < c2) begin
						phase_q <= 5'(p_q);
						bx_q <= nx_q;
						bo_q <= no_q;
					end
					p_q <= p_q + 1'b1;
					state_q <= (p_q + 1'b1 >= entries_q) ? ST_OUT : ST_RD;
				end
				ST_OUT: begin
					if (!res_q || res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/working_set_phase_detector.sv
// top level of the working set phase detector
// a boundary result passes the front shift, hash and accumulate stages, the boundary queue and the back-end
//   compare and decision states, plus a read and compare of each stored phase when the signature is unstable
// one address per cycle while full is low; the back end works on one boundary at a time, search included,
//   a four-deep queue absorbs boundaries and full rises while it is full and a boundary waits
// a write to interval_length holds full while the counter remainder is rebuilt
// reset: asynchronous, active low; registers return to their documented defaults
module working_set_phase_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] instr_address,
	output logic        empty,
	input  logic        pop,
	output logic signed [4:0] phase_id,
	output logic        phase_created,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] interval_q;
	logic [8:0]  thresh_q;
	logic [7:0]  stable_need_q;
	logic [5:0]  drop_q;
	logic        interval_wr;
	wspd_pkg::wspd_job_t fjob;
	wspd_pkg::wspd_job_t qbuf [wspd_pkg::QDepth];
	logic [wspd_pkg::QPtrW:0] wp_q;
	logic [wspd_pkg::QPtrW:0] rp_q;
	logic q_full;
	logic q_push;
	logic q_take;
	logic res_valid;
	logic [4:0] pid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 32'd10000;
			thresh_q <= 9'd128;
			stable_need_q <= 8'd3;
			drop_q <= 6'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				wspd_pkg::RegInterval: interval_q <= cfg_data;
				wspd_pkg::RegThresh:   thresh_q <= cfg_data[8:0];
				wspd_pkg::RegStable:   stable_need_q <= cfg_data[7:0];
				wspd_pkg::RegDrop:     drop_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end
	assign interval_wr = cfg_we && (cfg_index == wspd_pkg::RegInterval);

	wspd_front u_front (
		.clk, .arst_n, .push, .full, .instr_address,
		.interval_length(interval_q), .interval_wr, .dropped_low_bits(drop_q),
		.q_full, .q_push, .q_job(fjob)
	);

	// boundary queue between front and back
	assign q_full = (wp_q[wspd_pkg::QPtrW] != rp_q[wspd_pkg::QPtrW]) &&
		(wp_q[wspd_pkg::QPtrW-1:0] == rp_q[wspd_pkg::QPtrW-1:0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (q_push)
				wp_q <= wp_q + 1'b1;
			if (q_take)
				rp_q <= rp_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (q_push)
			qbuf[wp_q[wspd_pkg::QPtrW-1:0]] <= fjob;
	end

	wspd_back u_back (
		.clk, .arst_n, .job_valid(wp_q != rp_q), .job_take(q_take),
		.job(qbuf[rp_q[wspd_pkg::QPtrW-1:0]]),
		.threshold_q8(thresh_q), .stable_intervals_needed(stable_need_q),
		.res_valid, .res_take(pop), .phase_id(pid), .phase_created
	);
	assign empty = !res_valid;
	assign phase_id = pid;

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("boundary queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> (wp_q != rp_q)) else $error("boundary queue underflow");
	a_created_id: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && phase_created) |-> (pid != wspd_pkg::PhaseNone))
		else $error("created phase without id");
endmodule

### tb/working_set_phase_detector_check.sv
// checker for the working set phase detector: predicts phase decisions and compares results
module working_set_phase_detector_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [63:0]       instr_address,
	input  logic              empty,
	input  logic              pop,
	input  logic signed [4:0] phase_id,
	input  logic              phase_created,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0] id;
		logic       created;
	} decision_t;

	// mirrored configuration
	logic [31:0] intv_cfg;
	logic [8:0]  thresh_q8;
	logic [7:0]  stable_need;
	logic [5:0]  shift_cfg;

	// mirrored state
	logic [wspd_pkg::SigBits-1:0] cur_sig;
	logic [wspd_pkg::SigBits-1:0] prev_sig;
	logic [wspd_pkg::SigBits-1:0] phase_sigs [wspd_pkg::MaxPhases];
	int                 phase_count;
	logic [31:0]        instr_cnt;
	int                 stable_cnt;
	int                 phase_now;

	decision_t decisions_q[$];

	assign pending = decisions_q.size();

	// population counts of xor and or of two signatures
	function automatic void sig_distance(input logic [wspd_pkg::SigBits-1:0] a,
		input logic [wspd_pkg::SigBits-1:0] b, output longint nx, output longint no);
		nx = $countones(a ^ b);
		no = $countones(a | b);
	endfunction

	function automatic bit is_close(input longint nx, input longint no);
		if (no == 0) return 0;
		return nx * 256 < longint'(thresh_q8) * no;
	endfunction

	task automatic predict_phase(input logic [63:0] addr);
		logic [63:0]  v;
		logic [63:0]  prod;
		logic [31:0]  h;
		int           idx;
		bit           boundary;
		longint       nx, no, best_x, best_o;
		bit           made;
		decision_t    d;
		v = addr >> shift_cfg;
		prod = v * wspd_pkg::HashMult;
		h = prod[63:32];
		idx = int'(h >> (32 - wspd_pkg::SigLog2));
		cur_sig[idx] = 1'b1;
		if (intv_cfg == 0) boundary = (instr_cnt == 0);
		else boundary = (instr_cnt % intv_cfg) == 0;
		if (boundary) begin
			made = 0;
			sig_distance(cur_sig, prev_sig, nx, no);
			if (is_close(nx, no)) begin
				if (stable_cnt < 255) stable_cnt++;
				if (stable_cnt >= stable_need && phase_now == -1 &&
					phase_count < wspd_pkg::MaxPhases) begin
					phase_sigs[phase_count] = cur_sig;
					phase_now = phase_count;
					phase_count++;
					made = 1;
				end
			end else begin
				best_x = thresh_q8;
				best_o = 256;
				stable_cnt = 0;
				phase_now = -1;
				for (int p = 0; p < phase_count; p++) begin
					sig_distance(cur_sig, phase_sigs[p], nx, no);
					if (is_close(nx, no) && nx * best_o < best_x * no) begin
						phase_now = p;
						best_x = nx;
						best_o = no;
					end
				end
			end
			prev_sig = cur_sig;
			cur_sig = '0;
			d.id = phase_now[4:0];
			d.created = made;
			decisions_q = {decisions_q, d};
		end
		instr_cnt++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// watch configuration, input and result transactions
	always @(posedge clk or negedge arst_n) begin
		decision_t d;
		if (!arst_n) begin
			intv_cfg = 10000;
			thresh_q8 = 128;
			stable_need = 3;
			shift_cfg = 3;
			cur_sig = '0;
			prev_sig = '0;
			phase_count = 0;
			instr_cnt = 0;
			stable_cnt = 0;
			phase_now = -1;
			decisions_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wspd_pkg::RegInterval: intv_cfg = cfg_data;
					wspd_pkg::RegThresh:   thresh_q8 = cfg_data[8:0];
					wspd_pkg::RegStable:   stable_need = cfg_data[7:0];
					wspd_pkg::RegDrop:     shift_cfg = cfg_data[5:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (decisions_q.size() == 0) report_mismatch("result with nothing expected");
				else begin
					d = decisions_q.pop_front();
					if (phase_id !== d.id)
						report_mismatch($sformatf("phase_id %0d expected %0d", phase_id,
							$signed(d.id)));
					if (phase_created !== d.created)
						report_mismatch($sformatf("phase_created %0b expected %0b",
							phase_created, d.created));
				end
			end
			if (push && !full) predict_phase(instr_address);
		end
	end
endmodule

### tb/working_set_phase_detector_test.sv
// stimulus and verdict for the working set phase detector
module working_set_phase_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              push = 0;
	logic              full;
	logic [63:0]       instr_address = '0;
	logic              empty;
	logic              pop = 0;
	logic signed [4:0] phase_id;
	logic              phase_created;
	logic              cfg_we = 0;
	logic [1:0]        cfg_index = wspd_pkg::RegInterval;
	logic [31:0]       cfg_data = '0;
	int                fail_count;
	int                pending;
	bit                stim_done = 0;

	logic [63:0] region_base;
	int          region_span;

	working_set_phase_detector i_dut (.*);

	working_set_phase_detector_check i_check (.*);

	always #2 clk = ~clk;

	// run limit
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// one input transaction, after a random gap when gaps is set
	task automatic send_addr(input logic [63:0] a, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 19) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		instr_address <= a;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// wait until idle, then let the back end settle
	task automatic drain();
		push <= 0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// address from a working set: mostly a small code region, sometimes noise
	function automatic logic [63:0] region_addr();
		if ($urandom_range(0, 19) == 0) return rand64();
		return region_base + 64'($urandom_range(0, region_span - 1));
	endfunction

	// result side: random stalls per transaction
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		int ilen;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, field extremes, first item is a boundary
		send_addr('0, 0);
		send_addr('1, 0);
		for (int b = 0; b < 64; b += 9) send_addr(64'h1 << b, 0);
		drain();
		// zero interval, full threshold, stable minimum zero, no dropped bits
		write_reg(wspd_pkg::RegInterval, 0);
		write_reg(wspd_pkg::RegThresh, 256);
		write_reg(wspd_pkg::RegStable, 0);
		write_reg(wspd_pkg::RegDrop, 0);
		repeat (6) send_addr(rand64(), 1);
		drain();
		// every item a boundary: stable runs and saturation of the stable count
		write_reg(wspd_pkg::RegInterval, 1);
		write_reg(wspd_pkg::RegThresh, 511);
		write_reg(wspd_pkg::RegDrop, 63);
		repeat (300) send_addr(64'h8000_0000_0000_0000 | 64'($urandom_range(0, 1)), 0);
		drain();
		write_reg(wspd_pkg::RegThresh, 0);
		write_reg(wspd_pkg::RegStable, 255);
		repeat (20) send_addr(rand64(), 1);
		drain();

		// random phases of program-like address streams
		for (int ph = 0; ph < 14; ph++) begin
			ilen = $urandom_range(1, 12);
			write_reg(wspd_pkg::RegInterval, ilen);
			write_reg(wspd_pkg::RegThresh, $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
				: $urandom_range(40, 256));
			write_reg(wspd_pkg::RegStable, $urandom_range(0, 4));
			write_reg(wspd_pkg::RegDrop, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
				: $urandom_range(0, 6));
			for (int n = 0; n < 75; n++) begin
				if (n % (ilen * 4) == 0) begin
					region_base = (ph % 3 == 0) ? rand64()
						: 64'h40_0000 + 64'($urandom_range(0, 5)) * 64'h1000;
					region_span = $urandom_range(1, 64);
				end
				send_addr(region_addr(), ph % 4 != 3);
			end
			drain();
		end
		// huge interval: no boundary within the items sent
		write_reg(wspd_pkg::RegInterval, 32'hFFFF_FFFF);
		repeat (10) send_addr(rand64(), 1);
		drain();
		stim_done = 1;
	end

	// verdict
	initial begin
		wait (stim_done);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
sv/wspd_pkg.sv
sv/wspd_front.sv
sv/wspd_back.sv
sv/working_set_phase_detector.sv
tb/working_set_phase_detector_check.sv
tb/working_set_phase_detector_test.sv
